/* hw/rtl/watrt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// watrt_pkg
// Shared types, constants and helpers of the weekly alarm table relay timer.
// ----------------------------------------------------------------------------
package watrt_pkg;

  localparam int ALARM_SLOTS_DEF = 32;
  localparam int DAY_BIT_BASE    = 8;

  localparam int COUNT_W = 6;
  localparam int SLOT_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int DAYS_W  = 8;
  localparam int DUR_W   = 16;
  localparam int DOW_W   = 3;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 6;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;

  // request kinds on in_tuser
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_ALARM_COUNT     = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_SWITCH_MODE     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_PROGRAM_ENABLED = 2'd2;

  // slot write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [DAYS_W-1:0] days;
    logic [DUR_W-1:0]  dur;
  } wr_t;

  // current time of the tick under scan, held steady during the scan
  typedef struct packed {
    logic              armed;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [DOW_W-1:0]  dow;
  } query_t;

  // token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [SLOT_W-1:0] fidx;
    logic [DUR_W-1:0]  dur;
  } probe_t;

  // weekday dow selects day-mask bit (8 - dow); other weekdays never match
  function automatic logic day_hit(input logic [DAYS_W-1:0] days, input logic [DOW_W-1:0] dow);
    logic hit;
    hit = 1'b0;
    case (dow)
      3'd1:    hit = days[DAY_BIT_BASE-1];
      3'd2:    hit = days[DAY_BIT_BASE-2];
      3'd3:    hit = days[DAY_BIT_BASE-3];
      3'd4:    hit = days[DAY_BIT_BASE-4];
      3'd5:    hit = days[DAY_BIT_BASE-5];
      3'd6:    hit = days[DAY_BIT_BASE-6];
      3'd7:    hit = days[DAY_BIT_BASE-7];
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/watrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// watrt_cell
// One alarm slot: holds its entry and passes the scan token on, claiming it
// when the slot is the first match.
// ----------------------------------------------------------------------------
module watrt_cell
  import watrt_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire wr_t                wr_i,
  input  wire query_t             query_i,
  input  wire logic [COUNT_W-1:0] count_i,
  input  wire probe_t             probe_i,
  output probe_t                  probe_o
);

  logic [HOUR_W-1:0] hour_r;
  logic [MIN_W-1:0]  minute_r;
  logic [DAYS_W-1:0] days_r;
  logic [DUR_W-1:0]  dur_r;
  probe_t            probe_r;
  probe_t            probe_nxt;
  logic              active;
  logic              sel;
  logic              hit;

  assign active = (9'(count_i) > 9'(IDX));
  assign sel    = wr_i.en && (9'(wr_i.slot) == 9'(IDX));

  assign hit = probe_i.valid && !probe_i.found && query_i.armed && active &&
               days_r[0] && (hour_r == query_i.hour) && (minute_r == query_i.minute) &&
               day_hit(days_r, query_i.dow);

  always_comb begin
    probe_nxt = probe_i;
    if (hit) begin
      probe_nxt.found = 1'b1;
      probe_nxt.fidx  = SLOT_W'(IDX);
      probe_nxt.dur   = dur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      hour_r   <= wr_i.hour;
      minute_r <= wr_i.minute;
      days_r   <= wr_i.days;
      dur_r    <= wr_i.dur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= '0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_o = probe_r;

endmodule
`default_nettype wire

/* hw/rtl/weekly_alarm_table_relay_timer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weekly_alarm_table_relay_timer
// Weekly time switch: a row of alarm slot cells scanned by a token on every
// one-second tick; alarms match only on a new minute; drives relay, lamp, buzzer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per request. in_tuser = 0 writes one slot of the table,
//           in_tuser = 1 is the one-second tick carrying the current time.
//   out_* : exactly one word per request, in request order: relay, lamp,
//           buzzer, fired flag and the index of the first matching slot.
//   cfg_* : alarm count, switch mode and program enable; write while idle.
// Flow:
//   a write request goes from idle to the done state and gives its word from
//   the output register; a tick walks its token through all ALARM_SLOTS cells,
//   one cell a cycle, then gives its word through the done state. One request
//   is in work at a time: in_tready is high only while idle, so the next one
//   waits until the last word is handed to the output register.
// Reset clears the relay, lamp, countdown and last minute, the registers and
//   the output; the slot table holds nothing until written.
// A stalled receiver holds the finished word in the output register; the
//   block then finishes the next request and waits until the register frees.
// ----------------------------------------------------------------------------
module weekly_alarm_table_relay_timer
  import watrt_pkg::*;
#(
  parameter int ALARM_SLOTS = ALARM_SLOTS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // slot[4:0] entry_hour[9:5] entry_minute[15:10] entry_days[23:16]
  // entry_duration[39:24] hour_now[44:40] minute_now[50:45] day_of_week[53:51]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[0]
  input  wire logic [0:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // relay_on[0] led_on[1] buzzer_on[2] alarm_fired[3] fired_slot[8:4]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CIDX_W-1:0]     cfg_index,
  input  wire logic [CDATA_W-1:0]    cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0] alarm_count_r;
  logic               switch_mode_r;
  logic               program_enabled_r;

  logic [DUR_W-1:0]   rem_r, rem_nxt;
  logic [MIN_W-1:0]   last_min_r, last_min_nxt;
  logic               relay_r, relay_nxt;
  logic               led_r, led_nxt;

  logic               res_buzz_r, res_buzz_nxt;
  logic               res_fired_r, res_fired_nxt;
  logic [SLOT_W-1:0]  res_fslot_r, res_fslot_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  query_t             query_r, query_nxt;
  probe_t             launch_r, launch_nxt;
  probe_t             chain_w [ALARM_SLOTS+1];
  wr_t                wr_bus;

  logic               in_acc;
  logic               is_tick;
  logic [HOUR_W-1:0]  hour_now;
  logic [MIN_W-1:0]   minute_now;
  logic [DOW_W-1:0]   dow_now;
  probe_t             scan_end;
  logic [DUR_W-1:0]   rem_eff;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign is_tick    = (in_tuser[0] == REQ_TICK);
  assign hour_now   = in_tdata[44:40];
  assign minute_now = in_tdata[50:45];
  assign dow_now    = in_tdata[53:51];

  assign wr_bus.en     = in_acc && (in_tuser[0] == REQ_WRITE);
  assign wr_bus.slot   = in_tdata[4:0];
  assign wr_bus.hour   = in_tdata[9:5];
  assign wr_bus.minute = in_tdata[15:10];
  assign wr_bus.days   = in_tdata[23:16];
  assign wr_bus.dur    = in_tdata[39:24];

  assign chain_w[0] = launch_r;
  assign scan_end   = chain_w[ALARM_SLOTS];

  for (genvar g = 0; g < ALARM_SLOTS; g++) begin : g_cell
    watrt_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_i    (wr_bus),
      .query_i (query_r),
      .count_i (alarm_count_r),
      .probe_i (chain_w[g]),
      .probe_o (chain_w[g+1])
    );
  end

  // a match in pulse mode reloads the countdown before it is stepped
  assign rem_eff = (scan_end.found && !switch_mode_r) ? scan_end.dur : rem_r;

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    last_min_nxt  = last_min_r;
    relay_nxt     = relay_r;
    led_nxt       = led_r;
    res_buzz_nxt  = res_buzz_r;
    res_fired_nxt = res_fired_r;
    res_fslot_nxt = res_fslot_r;
    query_nxt     = query_r;
    launch_nxt    = launch_r;
    launch_nxt.valid = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_buzz_nxt  = 1'b0;
          res_fired_nxt = 1'b0;
          res_fslot_nxt = '0;
          if (is_tick) begin
            query_nxt.armed  = (minute_now != last_min_r) && program_enabled_r;
            query_nxt.hour   = hour_now;
            query_nxt.minute = minute_now;
            query_nxt.dow    = dow_now;
            last_min_nxt     = minute_now;
            launch_nxt       = '0;
            launch_nxt.valid = 1'b1;
            state_nxt        = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end.valid) begin
          res_fired_nxt = scan_end.found;
          res_fslot_nxt = scan_end.found ? scan_end.fidx : '0;
          if (switch_mode_r) begin
            if (scan_end.found) begin
              relay_nxt = (scan_end.dur != '0);
              led_nxt   = (scan_end.dur != '0);
            end
          end else if (rem_eff == '0) begin
            rem_nxt   = '0;
            relay_nxt = 1'b0;
          end else begin
            rem_nxt      = rem_eff - DUR_W'(1);
            relay_nxt    = 1'b1;
            res_buzz_nxt = 1'b1;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, res_fslot_r, res_fired_r, res_buzz_r, led_r, relay_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      alarm_count_r     <= '0;
      switch_mode_r     <= 1'b0;
      program_enabled_r <= 1'b0;
      rem_r             <= '0;
      last_min_r        <= '0;
      relay_r           <= 1'b0;
      led_r             <= 1'b0;
      out_valid_r       <= 1'b0;
      launch_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      last_min_r  <= last_min_nxt;
      relay_r     <= relay_nxt;
      led_r       <= led_nxt;
      out_valid_r <= out_valid_nxt;
      launch_r    <= launch_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ALARM_COUNT:     alarm_count_r     <= cfg_wdata;
          CFG_SWITCH_MODE:     switch_mode_r     <= cfg_wdata[0];
          CFG_PROGRAM_ENABLED: program_enabled_r <= cfg_wdata[0];
          default:             ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_buzz_r  <= res_buzz_nxt;
    res_fired_r <= res_fired_nxt;
    res_fslot_r <= res_fslot_nxt;
    query_r     <= query_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weekly alarm table relay timer. Slot writes and
// one-second ticks go in on the input stream, and every status word coming
// back is compared with an in-bench model of the alarm table, the countdown
// and the relay and lamp levels. Runs over pulse and switch mode, several
// alarm counts and program enable off, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  import watrt_pkg::*;

  localparam int SLOTS = ALARM_SLOTS_DEF;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [HOUR_W-1:0] e_hour;
    logic [MIN_W-1:0]  e_min;
    logic [DAYS_W-1:0] e_days;
    logic [DUR_W-1:0]  e_dur;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [DOW_W-1:0]  dow;
  } req_t;

  typedef struct packed {
    logic              relay;
    logic              led;
    logic              buzzer;
    logic              fired;
    logic [SLOT_W-1:0] fslot;
  } status_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en;
  logic [CIDX_W-1:0]     cfg_index;
  logic [CDATA_W-1:0]    cfg_wdata;

  weekly_alarm_table_relay_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // model state of the timer
  logic [HOUR_W-1:0]  tbl_hour [SLOTS];
  logic [MIN_W-1:0]   tbl_min  [SLOTS];
  logic [DAYS_W-1:0]  tbl_days [SLOTS];
  logic [DUR_W-1:0]   tbl_dur  [SLOTS];
  logic [DUR_W-1:0]   countdown;
  logic [MIN_W-1:0]   prev_minute;
  logic               relay_lvl;
  logic               led_lvl;
  logic [COUNT_W-1:0] cfg_count;
  logic               cfg_switch;
  logic               cfg_enable;

  status_t pending_status[$];
  status_t want_status;

  int errors;
  int words_in;
  int ticks_in;
  int words_out;
  int fires_seen;
  int buzz_seen;
  bit stall_in;
  bit stall_out;

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // next status word of the timer for one accepted request
  function automatic status_t step_timer(input req_t r);
    status_t s;
    int n;
    s = '0;
    if (r.kind == REQ_WRITE) begin
      tbl_hour[r.slot] = r.e_hour;
      tbl_min[r.slot]  = r.e_min;
      tbl_days[r.slot] = r.e_days;
      tbl_dur[r.slot]  = r.e_dur;
    end else begin
      if (r.minute != prev_minute && cfg_enable) begin
        n = (cfg_count > SLOTS) ? SLOTS : int'(cfg_count);
        for (int i = 0; i < n && !s.fired; i++) begin
          // weekday dow lives in day bit (8 - dow)
          if (tbl_days[i][0] && tbl_hour[i] == r.hour && tbl_min[i] == r.minute &&
              r.dow >= 1 && r.dow <= 7 && tbl_days[i][DAY_BIT_BASE - r.dow]) begin
            s.fired = 1'b1;
            s.fslot = SLOT_W'(i);
            if (!cfg_switch) begin
              countdown = tbl_dur[i];
            end else begin
              relay_lvl = (tbl_dur[i] != 0);
              led_lvl   = relay_lvl;
            end
          end
        end
      end
      prev_minute = r.minute;
      if (!cfg_switch) begin
        if (countdown == 0) begin
          relay_lvl = 1'b0;
        end else begin
          relay_lvl = 1'b1;
          countdown = countdown - 1'b1;
          s.buzzer  = 1'b1;
        end
      end
    end
    s.relay = relay_lvl;
    s.led   = led_lvl;
    return s;
  endfunction

  function automatic logic [DUR_W-1:0] rand_duration();
    logic [DUR_W-1:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: d = DUR_W'($urandom_range(0, 4));
      5, 6, 7:       d = DUR_W'($urandom_range(5, 30));
      8:             d = 16'hFFFF;
      default:       d = DUR_W'($urandom);
    endcase
    return d;
  endfunction

  // every field random within its range; callers overwrite what matters
  function automatic req_t rand_req();
    req_t r;
    r.kind   = REQ_TICK;
    r.slot   = SLOT_W'($urandom_range(0, SLOTS - 1));
    r.e_hour = HOUR_W'($urandom_range(0, 23));
    r.e_min  = MIN_W'($urandom_range(0, 59));
    r.e_days = DAYS_W'($urandom);
    r.e_dur  = rand_duration();
    r.hour   = HOUR_W'($urandom_range(0, 23));
    r.minute = MIN_W'($urandom_range(0, 59));
    r.dow    = DOW_W'($urandom_range(1, 7));
    return r;
  endfunction

  function automatic req_t write_req(input int slot, input int h, input int m,
                                     input logic [DAYS_W-1:0] days,
                                     input logic [DUR_W-1:0] dur);
    req_t r;
    r        = rand_req();
    r.kind   = REQ_WRITE;
    r.slot   = SLOT_W'(slot);
    r.e_hour = HOUR_W'(h);
    r.e_min  = MIN_W'(m);
    r.e_days = days;
    r.e_dur  = dur;
    return r;
  endfunction

  function automatic req_t tick_req(input int h, input int m, input int dow);
    req_t r;
    r        = rand_req();
    r.kind   = REQ_TICK;
    r.hour   = HOUR_W'(h);
    r.minute = MIN_W'(m);
    r.dow    = DOW_W'(dow);
    return r;
  endfunction

  // entered and left at a falling edge; valid stays up when no gap follows
  task automatic send_word(input req_t r);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {2'b00, r.dow, r.minute, r.hour, r.e_dur, r.e_days,
                  r.e_min, r.e_hour, r.slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_status.push_back(step_timer(r));
    words_in++;
    if (r.kind == REQ_TICK) ticks_in++;
    @(negedge clk);
    gap = stall_in ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic configure(input int count, input bit sw, input bit en);
    drain();
    write_reg(CFG_ALARM_COUNT, CDATA_W'(count));
    write_reg(CFG_SWITCH_MODE, CDATA_W'(sw));
    write_reg(CFG_PROGRAM_ENABLED, CDATA_W'(en));
    cfg_wr_en  <= 1'b0;
    cfg_count  = COUNT_W'(count);
    cfg_switch = sw;
    cfg_enable = en;
  endtask

  // fill every slot with a disabled alarm so no scan ever reads an empty slot
  task automatic test_load_table();
    req_t r;
    configure(0, 1'b0, 1'b0);
    for (int i = 0; i < SLOTS; i++) begin
      r = write_req(i, $urandom_range(0, 23), $urandom_range(0, 59),
                    DAYS_W'($urandom) & 8'hFE, rand_duration());
      send_word(r);
    end
  endtask

  task automatic test_pulse_directed();
    configure(SLOTS, 1'b0, 1'b1);
    send_word(write_req(0, 23, 59, 8'hFF, 16'd2));
    send_word(write_req(31, 12, 30, 8'h03, 16'hFFFF));
    send_word(write_req(2, 5, 1, 8'h81, 16'd0));
    send_word(write_req(1, 0, 0, 8'h00, 16'hFFFF));
    send_word(tick_req(23, 59, 1));   // fires slot 0, two seconds
    send_word(tick_req(23, 59, 1));
    send_word(tick_req(23, 59, 1));   // countdown done, relay drops
    send_word(tick_req(0, 0, 4));     // disabled slot never fires
    send_word(tick_req(12, 30, 7));   // last slot, longest countdown
    send_word(tick_req(5, 1, 1));     // zero duration cuts the countdown
    send_word(tick_req(23, 58, 0));
    send_word(tick_req(23, 59, 0));   // weekday zero matches nothing
  endtask

  task automatic test_switch_directed();
    configure(SLOTS, 1'b1, 1'b1);
    send_word(tick_req(12, 30, 7));   // relay and lamp on
    send_word(write_req(3, 7, 45, 8'h41, 16'd1));
    send_word(tick_req(7, 45, 2));
    send_word(tick_req(5, 1, 1));     // zero duration switches off
    send_word(tick_req(5, 1, 1));
  endtask

  task automatic test_count_limits();
    configure(SLOTS, 1'b0, 1'b1);
    send_word(write_req(31, 12, 30, 8'h03, 16'd1));
    configure(63, 1'b0, 1'b1);        // count above the table size
    send_word(tick_req(12, 30, 7));
    configure(0, 1'b0, 1'b1);
    send_word(tick_req(23, 59, 1));   // nothing scanned
    configure(SLOTS, 1'b0, 1'b0);
    send_word(tick_req(12, 30, 7));   // minute still tracked while disabled
    configure(SLOTS, 1'b0, 1'b1);
    send_word(tick_req(12, 30, 7));   // same minute, no scan
  endtask

  task automatic test_random();
    int counts [8] = '{32, 32, 1, 12, 63, 5, 32, 0};
    bit modes  [8] = '{0, 1, 0, 1, 0, 1, 0, 0};
    bit enables[8] = '{1, 1, 1, 1, 1, 0, 1, 1};
    req_t r;
    int lim;
    int pick;
    int t;
    int last_hour;
    int last_min;
    last_hour = 0;
    last_min  = 0;
    for (int p = 0; p < 8; p++) begin
      if (p == 7) begin
        counts[p] = $urandom_range(0, SLOTS);
        modes[p]  = $urandom_range(0, 1);
      end
      configure(counts[p], modes[p], enables[p]);
      lim = (counts[p] == 0 || counts[p] > SLOTS) ? SLOTS : counts[p];
      for (int k = 0; k < 100; k++) begin
        if (k % 25 == 0) begin
          stall_in  = $urandom_range(0, 2) != 0;
          stall_out = $urandom_range(0, 2) != 0;
        end
        r    = rand_req();
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          r.kind = REQ_WRITE;
          if ($urandom_range(0, 9) < 7) r.slot = SLOT_W'($urandom_range(0, lim - 1));
          r.e_days[0] = $urandom_range(0, 3) != 0;
        end else begin
          // mostly aim at a programmed time, often hold the minute to run countdowns
          if (pick < 65) begin
            t        = $urandom_range(0, lim - 1);
            r.hour   = tbl_hour[t];
            r.minute = tbl_min[t];
            if ($urandom_range(0, 9) == 0) r.dow = '0;
          end else if (pick < 88) begin
            r.hour   = HOUR_W'(last_hour);
            r.minute = MIN_W'(last_min);
          end else if ($urandom_range(0, 3) == 0) begin
            r.dow = '0;
          end
          last_hour = r.hour;
          last_min  = r.minute;
        end
        send_word(r);
      end
    end
    stall_in  = 1'b0;
    stall_out = 1'b0;
  endtask

  // result side: ready with random stalls between words
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
      gap = stall_out ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (pending_status.size() == 0) begin
        report_mismatch($sformatf("status word %h with nothing expected", out_tdata));
      end else begin
        want_status = pending_status.pop_front();
        if (want_status.fired)  fires_seen++;
        if (want_status.buzzer) buzz_seen++;
        if (out_tdata[0] !== want_status.relay)
          report_mismatch($sformatf("relay_on got %b want %b", out_tdata[0], want_status.relay));
        if (out_tdata[1] !== want_status.led)
          report_mismatch($sformatf("led_on got %b want %b", out_tdata[1], want_status.led));
        if (out_tdata[2] !== want_status.buzzer)
          report_mismatch($sformatf("buzzer_on got %b want %b", out_tdata[2],
                                    want_status.buzzer));
        if (out_tdata[3] !== want_status.fired)
          report_mismatch($sformatf("alarm_fired got %b want %b", out_tdata[3],
                                    want_status.fired));
        if (out_tdata[8:4] !== want_status.fslot)
          report_mismatch($sformatf("fired_slot got %0d want %0d", out_tdata[8:4],
                                    want_status.fslot));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d words still expected", pending_status.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    countdown   = '0;
    prev_minute = '0;
    relay_lvl   = 1'b0;
    led_lvl     = 1'b0;
    cfg_count   = '0;
    cfg_switch  = 1'b0;
    cfg_enable  = 1'b0;
    stall_in    = 1'b0;
    stall_out   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_load_table();
    test_pulse_directed();
    test_switch_directed();
    test_count_limits();
    test_random();

    drain();
    repeat (SLOTS + 8) @(posedge clk);
    $display("sent %0d words (%0d ticks), checked %0d status words", words_in, ticks_in,
             words_out);
    $display("%0d alarms fired, %0d buzzer seconds, %0d mismatches", fires_seen, buzz_seen,
             errors);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* weekly_alarm_table_relay_timer.f */
hw/rtl/watrt_pkg.sv
hw/rtl/watrt_cell.sv
hw/rtl/weekly_alarm_table_relay_timer.sv
tb/tb_top.sv
